>>> rtl/bilinear_rgb_image_scaler_assert.svh
// Assertion macros used by the checker file.
`ifndef BILINEAR_RGB_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_RGB_IMAGE_SCALER_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define BRS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define BRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds through reset.
`define BRS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/brs_pkg.sv
package brs_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int ADDR_W     = 16;
    localparam int COLOR_W    = 24;
    localparam int COORD_W    = 10;
    localparam int ZOOM_W     = 5;
    localparam int SIZE_REG_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_LEVEL = 2'd2;

    localparam logic FUNC_LOAD   = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    localparam int QUEUE_DEPTH = 4;

    // scaled size = size * (ZOOM_BIAS + zoom) / 10, the tenth taken by reciprocal
    localparam int ZOOM_BIAS   = 9;
    localparam int TENTH_DIV   = 10;
    localparam int RECIP_MUL   = 52428;
    localparam int RECIP_SHIFT = 19;

    localparam logic [SIZE_REG_W-1:0] RST_SRC_WIDTH  = 9'd256;
    localparam logic [SIZE_REG_W-1:0] RST_SRC_HEIGHT = 9'd256;
    localparam logic [ZOOM_W-1:0]     RST_ZOOM_LEVEL = 5'd1;

    typedef struct packed {
        logic [SIZE_REG_W-1:0] src_width;
        logic [SIZE_REG_W-1:0] src_height;
        logic [ZOOM_W-1:0]     zoom_level;
    } t_cfg;

    typedef struct packed {
        logic               is_render;
        logic               wr_en;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
    } t_item;

endpackage

>>> rtl/brs_ram.sv
module brs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> rtl/brs_front.sv
module brs_front import brs_pkg::*; #(
    parameter int STORE_DEPTH = 65536
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_func,
    input  logic [ADDR_W-1:0]  i_load_addr,
    input  logic [COLOR_W-1:0] i_load_color,
    input  logic [COORD_W-1:0] i_out_x,
    input  logic [COORD_W-1:0] i_out_y,
    output logic               o_full,
    input  logic               i_take,
    output logic               o_vld,
    output t_item              o_item
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    t_item         r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;
    logic          push_ok;
    logic          take_ok;
    t_item         n_item;

    assign o_full  = (r_cnt == (PW+1)'(QUEUE_DEPTH));
    assign o_vld   = (r_cnt != '0);
    assign push_ok = i_push && !o_full;
    assign take_ok = i_take && o_vld;

    // classify: loads beyond the store are marked here so they never write
    always_comb begin
        n_item.is_render = (i_func == FUNC_RENDER);
        n_item.wr_en     = (i_func == FUNC_LOAD) &&
                           ({16'd0, i_load_addr} < 32'(STORE_DEPTH));
        n_item.addr      = i_load_addr;
        n_item.color     = i_load_color;
        n_item.ox        = i_out_x;
        n_item.oy        = i_out_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wp <= r_wp + 1'b1;
            end
            if (take_ok) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(push_ok) - (PW+1)'(take_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wp] <= n_item;
        end
    end

    assign o_item = r_q[r_rp];

endmodule

>>> rtl/brs_div.sv
module brs_div #(
    parameter int LANES = 2,
    parameter int DW    = 36,
    parameter int VW    = 12,
    parameter int QB    = 17,
    parameter int SW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_vld,
    input  logic [LANES-1:0][DW-1:0]   i_num,
    input  logic [LANES-1:0][VW-1:0]   i_den,
    input  logic [SW-1:0]              i_side,
    output logic                       o_vld,
    output logic [LANES-1:0][QB-1:0]   o_quo,
    output logic [SW-1:0]              o_side
);

    // one quotient bit per stage; the dividend bits above its low QB bits seed the remainder
    logic                        r_vld  [1:QB];
    logic [SW-1:0]               r_side [1:QB];
    logic [LANES-1:0][DW-1:0]    r_num  [1:QB];
    logic [LANES-1:0][VW-1:0]    r_den  [1:QB];
    logic [LANES-1:0][VW-1:0]    r_rem  [1:QB];
    logic [LANES-1:0][QB-1:0]    r_quo  [1:QB];

    for (genvar s = 0; s < QB; s++) begin : g_stage
        logic                     p_vld;
        logic [SW-1:0]            p_side;
        logic [LANES-1:0][DW-1:0] p_num;
        logic [LANES-1:0][VW-1:0] p_den;
        logic [LANES-1:0][VW-1:0] p_rem;
        logic [LANES-1:0][QB-1:0] p_quo;
        logic [LANES-1:0][VW-1:0] n_rem;
        logic [LANES-1:0][QB-1:0] n_quo;

        if (s == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_side = i_side;
            assign p_num  = i_num;
            assign p_den  = i_den;
            for (genvar l = 0; l < LANES; l++) begin : g_seed
                assign p_rem[l] = VW'(i_num[l] >> QB);
                assign p_quo[l] = '0;
            end
        end else begin : g_next
            assign p_vld  = r_vld[s];
            assign p_side = r_side[s];
            assign p_num  = r_num[s];
            assign p_den  = r_den[s];
            assign p_rem  = r_rem[s];
            assign p_quo  = r_quo[s];
        end

        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic [VW:0] shifted;
            logic        ge;
            assign shifted  = {p_rem[l], p_num[l][QB-1-s]};
            assign ge       = (shifted >= {1'b0, p_den[l]});
            assign n_quo[l] = {p_quo[l][QB-2:0], ge};
            assign n_rem[l] = ge ? VW'(shifted - {1'b0, p_den[l]}) : VW'(shifted);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[s+1] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[s+1] <= p_side;
                r_num[s+1]  <= p_num;
                r_den[s+1]  <= p_den;
                r_rem[s+1]  <= n_rem;
                r_quo[s+1]  <= n_quo;
            end
        end
    end

    assign o_vld  = r_vld[QB];
    assign o_quo  = r_quo[QB];
    assign o_side = r_side[QB];

endmodule

>>> rtl/brs_back.sv
module brs_back import brs_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               i_vld,
    input  t_item              i_item,
    output logic               o_take,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_out_of_range
);

    localparam int SZW   = ($clog2(MAX_SRC_WIDTH + 1) > $clog2(MAX_SRC_HEIGHT + 1)) ?
                           $clog2(MAX_SRC_WIDTH + 1) : $clog2(MAX_SRC_HEIGHT + 1);
    localparam int DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int ZBW   = ZOOM_W + 1;
    localparam int PRW   = SZW + ZBW;
    localparam int OWW   = SZW + 2;
    localparam int TWW   = SZW + COORD_W;
    localparam int NW    = TWW + 1;
    localparam int DW    = NW + FRAC_BITS;
    localparam int VW    = OWW + 1;
    localparam int QB    = SZW + FRAC_BITS;
    localparam int MULW  = PRW + 17;
    localparam int SW    = 3 + AW + COLOR_W + 2 * SZW;

    function automatic logic [SZW-1:0] sat_size(input logic [SIZE_REG_W-1:0] v,
                                                input int unsigned max_v);
        logic [SZW-1:0] r;
        if (v == '0) begin
            r = SZW'(1);
        end else if (32'(v) > max_v) begin
            r = SZW'(max_v);
        end else begin
            r = SZW'(v);
        end
        return r;
    endfunction

    function automatic logic [COLOR_W-1:0] lerp_rgb(input logic [COLOR_W-1:0] a,
                                                    input logic [COLOR_W-1:0] b,
                                                    input logic [FRAC_BITS-1:0] p);
        logic [FRAC_BITS:0]   q;
        logic [FRAC_BITS+9:0] acc;
        logic [COLOR_W-1:0]   res;
        q   = ((FRAC_BITS+1)'(1) << FRAC_BITS) - {1'b0, p};
        res = '0;
        for (int c = 0; c < 3; c++) begin
            acc = (FRAC_BITS+10)'(a[c*8 +: 8]) * (FRAC_BITS+10)'(q) +
                  (FRAC_BITS+10)'(b[c*8 +: 8]) * (FRAC_BITS+10)'(p);
            res[c*8 +: 8] = acc[FRAC_BITS +: 8];
        end
        return res;
    endfunction

    logic en;
    logic r_out_vld;

    // the whole pipe advances together unless a finished word waits unpopped
    assign en      = !r_out_vld || i_pop;
    assign o_take  = en;
    assign o_empty = !r_out_vld;

    // stage 0: take the queue head
    logic  r_s0_vld;
    t_item r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0 <= i_item;
        end
    end

    // stage 1: saturate sizes, form size * (9 + zoom) and size * coordinate
    logic [SZW-1:0] w1, h1;
    logic [ZBW-1:0] zb;
    logic           r_s1_vld;
    t_item          r_s1;
    logic [SZW-1:0] r_s1_w, r_s1_h;
    logic [PRW-1:0] r_s1_prw, r_s1_prh;
    logic [TWW-1:0] r_s1_twx, r_s1_twy;

    assign w1 = sat_size(i_cfg.src_width, MAX_SRC_WIDTH);
    assign h1 = sat_size(i_cfg.src_height, MAX_SRC_HEIGHT);
    assign zb = ZBW'(i_cfg.zoom_level) + ZBW'(ZOOM_BIAS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en) begin
            r_s1_vld <= r_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1     <= r_s0;
            r_s1_w   <= w1;
            r_s1_h   <= h1;
            r_s1_prw <= PRW'(w1) * PRW'(zb);
            r_s1_prh <= PRW'(h1) * PRW'(zb);
            r_s1_twx <= TWW'(w1) * TWW'(r_s0.ox);
            r_s1_twy <= TWW'(h1) * TWW'(r_s0.oy);
        end
    end

    // stage 2: estimate of product / 10, low by at most one
    logic [MULW-1:0] mulw, mulh;
    logic            r_s2_vld;
    t_item           r_s2;
    logic [SZW-1:0]  r_s2_w, r_s2_h;
    logic [PRW-1:0]  r_s2_prw, r_s2_prh;
    logic [OWW-1:0]  r_s2_qw, r_s2_qh;
    logic [TWW-1:0]  r_s2_twx, r_s2_twy;

    assign mulw = MULW'(r_s1_prw) * MULW'(RECIP_MUL);
    assign mulh = MULW'(r_s1_prh) * MULW'(RECIP_MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2     <= r_s1;
            r_s2_w   <= r_s1_w;
            r_s2_h   <= r_s1_h;
            r_s2_prw <= r_s1_prw;
            r_s2_prh <= r_s1_prh;
            r_s2_qw  <= OWW'(mulw >> RECIP_SHIFT);
            r_s2_qh  <= OWW'(mulh >> RECIP_SHIFT);
            r_s2_twx <= r_s1_twx;
            r_s2_twy <= r_s1_twy;
        end
    end

    // stage 3: correct the estimate to give the scaled sizes
    logic [PRW-1:0] remw, remh;
    logic [OWW-1:0] ow3, oh3;
    logic           r_s3_vld;
    t_item          r_s3;
    logic [SZW-1:0] r_s3_w, r_s3_h;
    logic [OWW-1:0] r_s3_ow, r_s3_oh;
    logic [TWW-1:0] r_s3_twx, r_s3_twy;

    assign remw = r_s2_prw - ((PRW'(r_s2_qw) << 3) + (PRW'(r_s2_qw) << 1));
    assign remh = r_s2_prh - ((PRW'(r_s2_qh) << 3) + (PRW'(r_s2_qh) << 1));
    assign ow3  = r_s2_qw + OWW'(remw >= PRW'(TENTH_DIV));
    assign oh3  = r_s2_qh + OWW'(remh >= PRW'(TENTH_DIV));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (en) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3     <= r_s2;
            r_s3_w   <= r_s2_w;
            r_s3_h   <= r_s2_h;
            r_s3_ow  <= ow3;
            r_s3_oh  <= oh3;
            r_s3_twx <= r_s2_twx;
            r_s3_twy <= r_s2_twy;
        end
    end

    // range test and divider operands: (2*size*o - out) / (2*out) in Q.FRAC_BITS
    localparam int LANES_C = 2;

    logic                     oor3;
    logic [NW-1:0]            twx, twy, numx, numy;
    logic                     negx, negy;
    logic [LANES_C-1:0][DW-1:0] dnum;
    logic [LANES_C-1:0][VW-1:0] dden;
    logic [31:0]              a32;
    logic [SW-1:0]            side3;

    assign oor3 = (32'(r_s3.ox) >= 32'(r_s3_ow)) || (32'(r_s3.oy) >= 32'(r_s3_oh));
    assign twx  = {r_s3_twx, 1'b0};
    assign twy  = {r_s3_twy, 1'b0};
    assign negx = twx < NW'(r_s3_ow);
    assign negy = twy < NW'(r_s3_oh);
    assign numx = negx ? '0 : twx - NW'(r_s3_ow);
    assign numy = negy ? '0 : twy - NW'(r_s3_oh);
    assign dnum[0] = {numx, FRAC_BITS'(0)};
    assign dnum[1] = {numy, FRAC_BITS'(0)};
    assign dden[0] = {r_s3_ow, 1'b0};
    assign dden[1] = {r_s3_oh, 1'b0};
    assign a32   = 32'(r_s3.addr);
    assign side3 = {r_s3.is_render, r_s3.wr_en, oor3, a32[AW-1:0], r_s3.color,
                    r_s3_w, r_s3_h};

    logic                          d_vld;
    logic [LANES_C-1:0][QB-1:0]    d_quo;
    logic [SW-1:0]                 d_side;

    brs_div #(
        .LANES (LANES_C),
        .DW    (DW),
        .VW    (VW),
        .QB    (QB),
        .SW    (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s3_vld),
        .i_num   (dnum),
        .i_den   (dden),
        .i_side  (side3),
        .o_vld   (d_vld),
        .o_quo   (d_quo),
        .o_side  (d_side)
    );

    logic               d_render, d_wr_en, d_oor;
    logic [AW-1:0]      d_addr;
    logic [COLOR_W-1:0] d_color;
    logic [SZW-1:0]     d_w, d_h;

    assign {d_render, d_wr_en, d_oor, d_addr, d_color, d_w, d_h} = d_side;

    // stage 5: split floor and fraction, clamp, flag right column and bottom row
    logic [SZW-1:0]       fxr, fyr, wm1, hm1, fx5, fy5;
    logic                 r_s5_vld, r_s5_render, r_s5_wr_en, r_s5_oor;
    logic [AW-1:0]        r_s5_addr;
    logic [COLOR_W-1:0]   r_s5_color;
    logic [SZW-1:0]       r_s5_w, r_s5_fx, r_s5_fy;
    logic [FRAC_BITS-1:0] r_s5_px, r_s5_py;
    logic                 r_s5_right, r_s5_bottom;

    assign fxr = d_quo[0][QB-1:FRAC_BITS];
    assign fyr = d_quo[1][QB-1:FRAC_BITS];
    assign wm1 = d_w - 1'b1;
    assign hm1 = d_h - 1'b1;
    assign fx5 = (fxr > wm1) ? wm1 : fxr;
    assign fy5 = (fyr > hm1) ? hm1 : fyr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_vld <= 1'b0;
        end else if (en) begin
            r_s5_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s5_render <= d_render;
            r_s5_wr_en  <= d_wr_en;
            r_s5_oor    <= d_oor;
            r_s5_addr   <= d_addr;
            r_s5_color  <= d_color;
            r_s5_w      <= d_w;
            r_s5_fx     <= fx5;
            r_s5_fy     <= fy5;
            r_s5_px     <= d_quo[0][FRAC_BITS-1:0];
            r_s5_py     <= d_quo[1][FRAC_BITS-1:0];
            r_s5_right  <= (fx5 == wm1);
            r_s5_bottom <= (fy5 == hm1);
        end
    end

    // stage 6: top-left index, row-major
    logic                 r_s6_vld, r_s6_render, r_s6_wr_en, r_s6_oor;
    logic [AW-1:0]        r_s6_addr;
    logic [COLOR_W-1:0]   r_s6_color;
    logic [SZW-1:0]       r_s6_w;
    logic [AW:0]          r_s6_tl;
    logic [FRAC_BITS-1:0] r_s6_px, r_s6_py;
    logic                 r_s6_right, r_s6_bottom;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s6_vld <= 1'b0;
        end else if (en) begin
            r_s6_vld <= r_s5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s6_render <= r_s5_render;
            r_s6_wr_en  <= r_s5_wr_en;
            r_s6_oor    <= r_s5_oor;
            r_s6_addr   <= r_s5_addr;
            r_s6_color  <= r_s5_color;
            r_s6_w      <= r_s5_w;
            r_s6_tl     <= (AW+1)'((2*SZW)'(r_s5_fy) * (2*SZW)'(r_s5_w)) +
                           (AW+1)'(r_s5_fx);
            r_s6_px     <= r_s5_px;
            r_s6_py     <= r_s5_py;
            r_s6_right  <= r_s5_right;
            r_s6_bottom <= r_s5_bottom;
        end
    end

    // stage 7: four neighbours from two copies of the store, loads write both
    logic [AW:0]          tr_s, bl_s, br_s;
    logic                 we;
    logic [COLOR_W-1:0]   px_tl, px_tr, px_bl, px_br;
    logic                 r_s7_vld, r_s7_render, r_s7_oor;
    logic [FRAC_BITS-1:0] r_s7_px, r_s7_py;
    logic                 r_s7_right, r_s7_bottom;

    assign tr_s = r_s6_tl + 1'b1;
    assign bl_s = r_s6_tl + (AW+1)'(r_s6_w);
    assign br_s = bl_s + 1'b1;
    assign we   = en && r_s6_vld && r_s6_wr_en;

    brs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram_top (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_s6_addr),
        .i_wdata   (r_s6_color),
        .i_re      (en),
        .i_raddr_a (r_s6_tl[AW-1:0]),
        .i_raddr_b (tr_s[AW-1:0]),
        .o_rdata_a (px_tl),
        .o_rdata_b (px_tr)
    );

    brs_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram_bot (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (r_s6_addr),
        .i_wdata   (r_s6_color),
        .i_re      (en),
        .i_raddr_a (bl_s[AW-1:0]),
        .i_raddr_b (br_s[AW-1:0]),
        .o_rdata_a (px_bl),
        .o_rdata_b (px_br)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s7_vld <= 1'b0;
        end else if (en) begin
            r_s7_vld <= r_s6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s7_render <= r_s6_render;
            r_s7_oor    <= r_s6_oor;
            r_s7_px     <= r_s6_px;
            r_s7_py     <= r_s6_py;
            r_s7_right  <= r_s6_right;
            r_s7_bottom <= r_s6_bottom;
        end
    end

    // stage 8: horizontal blend; the right column passes the left pixels through
    logic                 r_s8_vld, r_s8_render, r_s8_oor, r_s8_bottom;
    logic [FRAC_BITS-1:0] r_s8_py;
    logic [COLOR_W-1:0]   r_s8_h0, r_s8_h1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s8_vld <= 1'b0;
        end else if (en) begin
            r_s8_vld <= r_s7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s8_render <= r_s7_render;
            r_s8_oor    <= r_s7_oor;
            r_s8_bottom <= r_s7_bottom;
            r_s8_py     <= r_s7_py;
            r_s8_h0     <= r_s7_right ? px_tl : lerp_rgb(px_tl, px_tr, r_s7_px);
            r_s8_h1     <= r_s7_right ? px_bl : lerp_rgb(px_bl, px_br, r_s7_px);
        end
    end

    // stage 9: vertical blend into the output word; the bottom row keeps the top blend
    logic [COLOR_W-1:0]   r_out_color;
    logic                 r_out_oor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_s8_vld && r_s8_render;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_color <= r_s8_oor    ? '0 :
                           r_s8_bottom ? r_s8_h0 : lerp_rgb(r_s8_h0, r_s8_h1, r_s8_py);
            r_out_oor   <= r_s8_oor;
        end
    end

    assign o_pixel_color  = r_out_color;
    assign o_out_of_range = r_out_oor;

endmodule

>>> rtl/bilinear_rgb_image_scaler.sv
// Bilinear RGB scaler. Load words (func 0) write one 24-bit pixel into the frame store,
// render words (func 1) return the interpolated colour of one pixel of the scaled
// image, or out_of_range with colour 0. One word is taken per clock when the result
// side keeps popping. A render passes through a pipelined divider that maps output
// coordinates back to the source, one quotient bit per stage. The frame store is
// held twice, each copy with two read ports, so all four neighbours are read in the
// same cycle; it is not cleared at reset and reads as undefined until loaded. Write
// the size and zoom registers only while no word is in flight.
module bilinear_rgb_image_scaler import brs_pkg::*; #(
    parameter int MAX_SRC_WIDTH  = 256,
    parameter int MAX_SRC_HEIGHT = 256,
    parameter int FRAC_BITS      = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  logic                  i_func,
    input  logic [ADDR_W-1:0]     i_load_addr,
    input  logic [COLOR_W-1:0]    i_load_color,
    input  logic [COORD_W-1:0]    i_out_x,
    input  logic [COORD_W-1:0]    i_out_y,
    output logic                  empty,
    input  logic                  pop,
    output logic [COLOR_W-1:0]    o_pixel_color,
    output logic                  o_out_of_range,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    logic  q_vld;
    logic  q_take;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width  <= RST_SRC_WIDTH;
            r_cfg.src_height <= RST_SRC_HEIGHT;
            r_cfg.zoom_level <= RST_ZOOM_LEVEL;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data;
                CFG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data;
                CFG_ZOOM_LEVEL: r_cfg.zoom_level <= i_cfg_data[ZOOM_W-1:0];
                default: begin
                    // unknown index: drop
                end
            endcase
        end
    end

    brs_front #(
        .STORE_DEPTH (MAX_SRC_WIDTH * MAX_SRC_HEIGHT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_func       (i_func),
        .i_load_addr  (i_load_addr),
        .i_load_color (i_load_color),
        .i_out_x      (i_out_x),
        .i_out_y      (i_out_y),
        .o_full       (full),
        .i_take       (q_take),
        .o_vld        (q_vld),
        .o_item       (q_item)
    );

    brs_back #(
        .MAX_SRC_WIDTH  (MAX_SRC_WIDTH),
        .MAX_SRC_HEIGHT (MAX_SRC_HEIGHT),
        .FRAC_BITS      (FRAC_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_vld          (q_vld),
        .i_item         (q_item),
        .o_take         (q_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_pixel_color  (o_pixel_color),
        .o_out_of_range (o_out_of_range)
    );

endmodule

>>> rtl/brs_chk.sv
`include "bilinear_rgb_image_scaler_assert.svh"

module brs_chk import brs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  push,
    input logic                  full,
    input logic                  i_func,
    input logic [ADDR_W-1:0]     i_load_addr,
    input logic [COLOR_W-1:0]    i_load_color,
    input logic [COORD_W-1:0]    i_out_x,
    input logic [COORD_W-1:0]    i_out_y,
    input logic                  empty,
    input logic                  pop,
    input logic [COLOR_W-1:0]    o_pixel_color,
    input logic                  o_out_of_range,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    `BRS_ASSERT_NEXT_ALWAYS(a_rst_empty, i_clk, !i_rst_n, empty, "result side not empty after reset")
    `BRS_ASSERT_NEXT_ALWAYS(a_rst_full, i_clk, !i_rst_n, !full, "queue full after reset")
    `BRS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_pixel_color) && $stable(o_out_of_range), "waiting result word changed")
    `BRS_ASSERT_NOW(a_oor_black, i_clk, i_rst_n, !empty && o_out_of_range, o_pixel_color == '0, "out of range word carries colour")

endmodule

bind bilinear_rgb_image_scaler brs_chk u_chk (.*);
